@@ rtl/core/lav_pkg.sv @@
// ----------------------------------------------------------------------------
// lav_pkg: shared types and constants of the look-at view matrix unit
// Field widths, fixed-point format, job record and back-end sequencer states.
// ----------------------------------------------------------------------------
package lav_pkg;

    // Fraction bits of unit vectors
    localparam int FRAC = 14;
    // Widths of unit, position and cross-product values
    localparam int UW   = 16;
    localparam int PW   = 32;
    localparam int CW   = 2 * UW + 1;
    localparam int DOTW = 2 * UW + 2;
    localparam int LW   = 15;
    localparam int LIMW = LW + FRAC;
    // Magnitude of a cross component, its square sum and its root
    localparam int MW   = CW - 1;
    localparam int SW   = 2 * MW;
    localparam int NW   = MW;
    // Divider: quotient bits and remainder width
    localparam int QB   = FRAC + 2;
    localparam int REMW = NW + QB;
    // Translation accumulator
    localparam int TW   = UW + PW + 2;
    localparam int CNTW = 5;

    localparam logic [LW-1:0] LIMIT_RESET = LW'(16220);

    // One classified request waiting for the back end
    typedef struct packed {
        logic [2:0][UW-1:0] v;
        logic [2:0][PW-1:0] p;
        logic [2:0][CW-1:0] c;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_SQRT,
        B_DVLD,
        B_DIV,
        B_UP,
        B_ROW
    } back_state_t;

endpackage

@@ rtl/core/look_at_view_matrix_unit.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit: camera look-at basis and view matrix rows
// Builds right, up and back vectors and emits view and inverse view rows.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request yields
// three rows (row_index 0, 1, 2, last_row on row 2), each shown for one cycle
// with out_valid high; the receiver cannot stall, so rows must be taken as
// they appear. The basis sequencer works on one request at a time: the
// square sum, the bit-per-cycle square root, the normalizing divider for
// each of the three components, the up vector and, for each row, the
// translation multiply-accumulate; that sequencer sets the sustained rate
// of requests. A two-entry queue and a capture stage let three further
// requests be taken while one is being worked on. On an idle unit a request
// passes the capture stage and the queue before the sequencer starts on it.
// The limit register is always ready and must be written only while the
// unit is idle.
module look_at_view_matrix_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] view_dir_x,
    input  logic signed [15:0] view_dir_y,
    input  logic signed [15:0] view_dir_z,
    input  logic signed [15:0] world_up_x,
    input  logic signed [15:0] world_up_y,
    input  logic signed [15:0] world_up_z,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [14:0]        cfg_data,
    output logic               out_valid,
    output logic [1:0]         row_index,
    output logic signed [15:0] view_c0,
    output logic signed [15:0] view_c1,
    output logic signed [15:0] view_c2,
    output logic signed [31:0] view_t,
    output logic signed [15:0] inv_c0,
    output logic signed [15:0] inv_c1,
    output logic signed [15:0] inv_c2,
    output logic signed [31:0] inv_t,
    output logic               last_row
);

    logic [lav_pkg::LW-1:0] limit_reg, limit_next;
    logic                   q_full, q_push, q_valid, q_pop;
    lav_pkg::job_t          push_data, pop_data;

    assign cfg_ready = 1'b1;

    // Update the parallel limit on a write
    always_comb
    begin
        limit_next = (cfg_valid && cfg_ready) ? cfg_data : limit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= lav_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    lav_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .view_dir_x (view_dir_x),
        .view_dir_y (view_dir_y),
        .view_dir_z (view_dir_z),
        .world_up_x (world_up_x),
        .world_up_y (world_up_y),
        .world_up_z (world_up_z),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .limit      (limit_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (push_data)
    );

    lav_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_data)
    );

    lav_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .row_index (row_index),
        .view_c0   (view_c0),
        .view_c1   (view_c1),
        .view_c2   (view_c2),
        .view_t    (view_t),
        .inv_c0    (inv_c0),
        .inv_c1    (inv_c1),
        .inv_c2    (inv_c2),
        .inv_t     (inv_t),
        .last_row  (last_row)
    );

endmodule

@@ rtl/core/lav_front.sv @@
// ----------------------------------------------------------------------------
// lav_front: request capture and basis classification
// Registers a request, runs the parallel test and forms the cross product.
// ----------------------------------------------------------------------------
module lav_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [15:0]         view_dir_x,
    input  logic signed [15:0]         view_dir_y,
    input  logic signed [15:0]         view_dir_z,
    input  logic signed [15:0]         world_up_x,
    input  logic signed [15:0]         world_up_y,
    input  logic signed [15:0]         world_up_z,
    input  logic signed [31:0]         pos_x,
    input  logic signed [31:0]         pos_y,
    input  logic signed [31:0]         pos_z,
    input  logic [lav_pkg::LW-1:0]     limit,
    input  logic                       q_full,
    output logic                       q_push,
    output lav_pkg::job_t              q_data
);

    logic                              s1_valid_reg, s1_valid_next;
    logic signed [lav_pkg::UW-1:0]     v_reg [3];
    logic signed [lav_pkg::UW-1:0]     u_reg [3];
    logic signed [lav_pkg::PW-1:0]     p_reg [3];
    logic                              accept;

    assign busy   = s1_valid_reg & q_full;
    assign accept = start & ~busy;
    assign q_push = s1_valid_reg & ~q_full;

    // Track the capture stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg[0] <= view_dir_x;
            v_reg[1] <= view_dir_y;
            v_reg[2] <= view_dir_z;
            u_reg[0] <= world_up_x;
            u_reg[1] <= world_up_y;
            u_reg[2] <= world_up_z;
            p_reg[0] <= pos_x;
            p_reg[1] <= pos_y;
            p_reg[2] <= pos_z;
        end
    end

    // Classify: parallel test, fallback axis choice, cross product
    always_comb
    begin
        logic signed [lav_pkg::DOTW-1:0] dot;
        logic        [lav_pkg::DOTW-1:0] dot_mag;
        logic        [lav_pkg::LIMW-1:0] lim;
        logic        [lav_pkg::UW:0]     vx_mag;
        logic signed [lav_pkg::CW-1:0]   c0, c1, c2;
        logic signed [lav_pkg::CW-1:0]   vx, vy, vz;
        dot = lav_pkg::DOTW'(v_reg[0] * u_reg[0]) + lav_pkg::DOTW'(v_reg[1] * u_reg[1])
            + lav_pkg::DOTW'(v_reg[2] * u_reg[2]);
        dot_mag = dot[lav_pkg::DOTW-1] ? lav_pkg::DOTW'(-dot) : lav_pkg::DOTW'(dot);
        lim = {limit, lav_pkg::FRAC'(0)};
        vx = lav_pkg::CW'(v_reg[0]);
        vy = lav_pkg::CW'(v_reg[1]);
        vz = lav_pkg::CW'(v_reg[2]);
        vx_mag = v_reg[0][lav_pkg::UW-1] ? (lav_pkg::UW+1)'(-vx) : (lav_pkg::UW+1)'(vx);
        if ({2'b00, dot_mag} > {{(lav_pkg::DOTW+2-lav_pkg::LIMW){1'b0}}, lim})
        begin
            if ({vx_mag, lav_pkg::FRAC'(0)} > (lav_pkg::UW+1+lav_pkg::FRAC)'(lim))
            begin
                c0 = -vz;
                c1 = '0;
                c2 = vx;
            end
            else
            begin
                c0 = '0;
                c1 = vz;
                c2 = -vy;
            end
        end
        else
        begin
            c0 = lav_pkg::CW'(v_reg[1] * u_reg[2]) - lav_pkg::CW'(v_reg[2] * u_reg[1]);
            c1 = lav_pkg::CW'(v_reg[2] * u_reg[0]) - lav_pkg::CW'(v_reg[0] * u_reg[2]);
            c2 = lav_pkg::CW'(v_reg[0] * u_reg[1]) - lav_pkg::CW'(v_reg[1] * u_reg[0]);
        end
        q_data.v[0] = v_reg[0];
        q_data.v[1] = v_reg[1];
        q_data.v[2] = v_reg[2];
        q_data.p[0] = p_reg[0];
        q_data.p[1] = p_reg[1];
        q_data.p[2] = p_reg[2];
        q_data.c[0] = c0;
        q_data.c[1] = c1;
        q_data.c[2] = c2;
    end

endmodule

@@ rtl/core/lav_queue.sv @@
// ----------------------------------------------------------------------------
// lav_queue: two-entry job queue
// Decouples the classifier from the basis sequencer.
// ----------------------------------------------------------------------------
module lav_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lav_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output lav_pkg::job_t pop_data
);

    lav_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store a pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/lav_back.sv @@
// ----------------------------------------------------------------------------
// lav_back: basis sequencer and row emitter
// Normalizes right, forms up and back, emits three matrix rows per job.
// ----------------------------------------------------------------------------
module lav_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  lav_pkg::job_t       q_data,
    output logic                q_pop,
    output logic                out_valid,
    output logic [1:0]          row_index,
    output logic signed [15:0]  view_c0,
    output logic signed [15:0]  view_c1,
    output logic signed [15:0]  view_c2,
    output logic signed [31:0]  view_t,
    output logic signed [15:0]  inv_c0,
    output logic signed [15:0]  inv_c1,
    output logic signed [15:0]  inv_c2,
    output logic signed [31:0]  inv_t,
    output logic                last_row
);

    localparam logic signed [lav_pkg::UW-1:0] SMAX = {1'b0, {(lav_pkg::UW-1){1'b1}}};
    localparam logic signed [lav_pkg::UW-1:0] SMIN = {1'b1, {(lav_pkg::UW-1){1'b0}}};

    lav_pkg::back_state_t              state_reg, state_next;
    lav_pkg::job_t                     job_reg, job_next;
    logic [lav_pkg::CNTW-1:0]          cnt_reg, cnt_next;
    logic [1:0]                        comp_reg, comp_next;
    logic [1:0]                        row_reg, row_next;
    logic [lav_pkg::SW-1:0]            acc_reg, acc_next;
    logic [lav_pkg::SW-1:0]            res_reg, res_next;
    logic [lav_pkg::SW-1:0]            bit_reg, bit_next;
    logic [lav_pkg::NW-1:0]            n_reg, n_next;
    logic [lav_pkg::REMW-1:0]          rem_reg, rem_next;
    logic [lav_pkg::QB-1:0]            q_reg, q_next;
    logic signed [lav_pkg::UW-1:0]     rt_reg [3];
    logic signed [lav_pkg::UW-1:0]     rt_next [3];
    logic signed [lav_pkg::UW-1:0]     up_reg [3];
    logic signed [lav_pkg::UW-1:0]     up_next [3];
    logic signed [lav_pkg::UW-1:0]     bk [3];
    logic signed [lav_pkg::TW-1:0]     tacc_reg, tacc_next;
    logic                              emit;
    logic signed [lav_pkg::PW-1:0]     t_out;

    logic                              out_valid_reg;
    logic [1:0]                        row_index_reg;
    logic signed [lav_pkg::UW-1:0]     view_c_reg [3];
    logic signed [lav_pkg::UW-1:0]     inv_c_reg [3];
    logic signed [lav_pkg::PW-1:0]     view_t_reg, inv_t_reg;
    logic                              last_row_reg;

    assign q_pop = (state_reg == lav_pkg::B_IDLE) && q_valid;
    assign emit  = (state_reg == lav_pkg::B_ROW) && (cnt_reg == lav_pkg::CNTW'(3));

    // Back vector: negated view, saturated
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bk[i] = (job_reg.v[i] == SMIN) ? SMAX : -$signed(job_reg.v[i]);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lav_pkg::B_IDLE:
                if (q_valid) state_next = lav_pkg::B_SQ;
            lav_pkg::B_SQ:
                if (cnt_reg == lav_pkg::CNTW'(2)) state_next = lav_pkg::B_SQRT;
            lav_pkg::B_SQRT:
                if (cnt_reg == lav_pkg::CNTW'(lav_pkg::SW / 2 - 1))
                    state_next = lav_pkg::B_DVLD;
            lav_pkg::B_DVLD:
                state_next = lav_pkg::B_DIV;
            lav_pkg::B_DIV:
                if (cnt_reg == lav_pkg::CNTW'(lav_pkg::QB - 1))
                    state_next = (comp_reg == 2'd2) ? lav_pkg::B_UP : lav_pkg::B_DVLD;
            lav_pkg::B_UP:
                if (cnt_reg == lav_pkg::CNTW'(2)) state_next = lav_pkg::B_ROW;
            lav_pkg::B_ROW:
                if (emit && row_reg == 2'd2) state_next = lav_pkg::B_IDLE;
            default:
                state_next = lav_pkg::B_IDLE;
        endcase
    end

    // Datapath: square sum, root, divide, up vector, translation
    always_comb
    begin
        logic [lav_pkg::MW-1:0]          mag;
        logic [lav_pkg::CW-1:0]          cv;
        logic [lav_pkg::SW:0]            trial;
        logic [lav_pkg::REMW-1:0]        dsor;
        logic [lav_pkg::REMW-1:0]        rem_t;
        logic                            qbit;
        logic [lav_pkg::QB-1:0]          qf;
        logic signed [lav_pkg::UW:0]     rv;
        logic signed [lav_pkg::UW-1:0]   ra, rc, va, vd;
        logic signed [lav_pkg::CW-1:0]   ud;
        logic [lav_pkg::CW-1:0]          ud_mag;
        logic [lav_pkg::CW-1:0]          um;
        logic signed [lav_pkg::UW-1:0]   bsel [3];
        logic [lav_pkg::TW-1:0]          t_mag;
        logic [lav_pkg::TW-1:0]          tm;
        job_next  = job_reg;
        cnt_next  = cnt_reg + lav_pkg::CNTW'(1);
        comp_next = comp_reg;
        row_next  = row_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        tacc_next = tacc_reg;
        t_out     = '0;
        // Clear scratch values
        trial  = '0;
        dsor   = '0;
        rem_t  = '0;
        qbit   = 1'b0;
        qf     = '0;
        rv     = '0;
        ra     = '0;
        rc     = '0;
        va     = '0;
        vd     = '0;
        ud     = '0;
        ud_mag = '0;
        um     = '0;
        t_mag  = '0;
        tm     = '0;
        for (int i = 0; i < 3; i++)
        begin
            rt_next[i] = rt_reg[i];
            up_next[i] = up_reg[i];
            bsel[i]    = '0;
        end
        cv  = job_reg.c[comp_reg];
        mag = cv[lav_pkg::CW-1] ? lav_pkg::MW'(-cv) : lav_pkg::MW'(cv);
        case (state_reg)
            lav_pkg::B_IDLE:
            begin
                job_next = q_data;
                cnt_next = '0;
                comp_next = 2'd0;
                acc_next = '0;
            end
            lav_pkg::B_SQ:
            begin
                cv  = job_reg.c[cnt_reg[1:0]];
                mag = cv[lav_pkg::CW-1] ? lav_pkg::MW'(-cv) : lav_pkg::MW'(cv);
                acc_next = acc_reg + (mag * mag);
                if (cnt_reg == lav_pkg::CNTW'(2))
                begin
                    cnt_next = '0;
                    res_next = '0;
                    bit_next = lav_pkg::SW'(1) << (lav_pkg::SW - 2);
                end
            end
            lav_pkg::B_SQRT:
            begin
                // One root bit per cycle, remainder kept in acc
                trial = {1'b0, res_reg} + {1'b0, bit_reg};
                if ({1'b0, acc_reg} >= trial)
                begin
                    acc_next = acc_reg - trial[lav_pkg::SW-1:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (cnt_reg == lav_pkg::CNTW'(lav_pkg::SW / 2 - 1))
                begin
                    n_next = res_next[lav_pkg::NW-1:0];
                    cnt_next = '0;
                end
            end
            lav_pkg::B_DVLD:
            begin
                rem_next = lav_pkg::REMW'({mag, lav_pkg::FRAC'(0)})
                         + lav_pkg::REMW'(n_reg >> 1);
                q_next   = '0;
                cnt_next = '0;
            end
            lav_pkg::B_DIV:
            begin
                // Restoring division, one quotient bit per cycle
                dsor  = lav_pkg::REMW'({n_reg, (lav_pkg::QB-1)'(0)});
                rem_t = rem_reg;
                qbit  = 1'b0;
                if (rem_reg >= dsor)
                begin
                    rem_t = rem_reg - dsor;
                    qbit  = 1'b1;
                end
                rem_next = rem_t << 1;
                q_next   = {q_reg[lav_pkg::QB-2:0], qbit};
                if (cnt_reg == lav_pkg::CNTW'(lav_pkg::QB - 1))
                begin
                    qf = q_next;
                    if (qf > lav_pkg::QB'(SMIN) && lav_pkg::QB > lav_pkg::UW - 1)
                    begin
                        qf = lav_pkg::QB'({1'b0, SMIN});
                    end
                    rv = cv[lav_pkg::CW-1] ? -$signed((lav_pkg::UW+1)'(qf))
                                          : $signed((lav_pkg::UW+1)'(qf));
                    if (n_reg == '0)
                        rt_next[comp_reg] = '0;
                    else if (rv > $signed((lav_pkg::UW+1)'(SMAX)))
                        rt_next[comp_reg] = SMAX;
                    else
                        rt_next[comp_reg] = lav_pkg::UW'(rv);
                    comp_next = comp_reg + 2'd1;
                    cnt_next  = '0;
                end
            end
            lav_pkg::B_UP:
            begin
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        ra = rt_reg[1]; va = job_reg.v[2]; rc = rt_reg[2]; vd = job_reg.v[1];
                    end
                    2'd1:
                    begin
                        ra = rt_reg[2]; va = job_reg.v[0]; rc = rt_reg[0]; vd = job_reg.v[2];
                    end
                    default:
                    begin
                        ra = rt_reg[0]; va = job_reg.v[1]; rc = rt_reg[1]; vd = job_reg.v[0];
                    end
                endcase
                ud     = lav_pkg::CW'(ra * va) - lav_pkg::CW'(rc * vd);
                ud_mag = ud[lav_pkg::CW-1] ? lav_pkg::CW'(-ud) : lav_pkg::CW'(ud);
                um     = (ud_mag + (lav_pkg::CW'(1) << (lav_pkg::FRAC - 1))) >> lav_pkg::FRAC;
                if (!ud[lav_pkg::CW-1] && um > lav_pkg::CW'(SMAX))
                    up_next[cnt_reg[1:0]] = SMAX;
                else if (ud[lav_pkg::CW-1] && um > lav_pkg::CW'({1'b0, SMIN}))
                    up_next[cnt_reg[1:0]] = SMIN;
                else if (ud[lav_pkg::CW-1])
                    up_next[cnt_reg[1:0]] = lav_pkg::UW'(-um);
                else
                    up_next[cnt_reg[1:0]] = lav_pkg::UW'(um);
                if (cnt_reg == lav_pkg::CNTW'(2))
                begin
                    cnt_next  = '0;
                    row_next  = 2'd0;
                    tacc_next = '0;
                end
            end
            lav_pkg::B_ROW:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    case (row_reg)
                        2'd0:    bsel[i] = rt_reg[i];
                        2'd1:    bsel[i] = up_reg[i];
                        default: bsel[i] = bk[i];
                    endcase
                end
                if (emit)
                begin
                    t_mag = tacc_reg[lav_pkg::TW-1] ? lav_pkg::TW'(-tacc_reg)
                                                   : lav_pkg::TW'(tacc_reg);
                    tm = (t_mag + (lav_pkg::TW'(1) << (lav_pkg::FRAC - 1))) >> lav_pkg::FRAC;
                    if (tacc_reg[lav_pkg::TW-1])
                        t_out = (tm > lav_pkg::TW'({1'b0, {(lav_pkg::PW-1){1'b1}}}))
                              ? {1'b0, {(lav_pkg::PW-1){1'b1}}} : lav_pkg::PW'(tm);
                    else
                        t_out = (tm > lav_pkg::TW'({1'b1, {(lav_pkg::PW-1){1'b0}}}))
                              ? {1'b1, {(lav_pkg::PW-1){1'b0}}} : lav_pkg::PW'(-tm);
                    cnt_next  = '0;
                    row_next  = row_reg + 2'd1;
                    tacc_next = '0;
                end
                else
                begin
                    tacc_next = tacc_reg + lav_pkg::TW'(bsel[cnt_reg[1:0]]
                              * $signed(job_reg.p[cnt_reg[1:0]]));
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lav_pkg::B_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= 2'd0;
            row_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            comp_reg      <= comp_next;
            row_reg       <= row_next;
            out_valid_reg <= emit;
        end
    end

    // Hold working values
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        tacc_reg <= tacc_next;
        for (int i = 0; i < 3; i++)
        begin
            rt_reg[i] <= rt_next[i];
            up_reg[i] <= up_next[i];
        end
    end

    // Register the emitted row
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            row_index_reg <= row_reg;
            view_t_reg    <= t_out;
            inv_t_reg     <= $signed(job_reg.p[row_reg]);
            last_row_reg  <= (row_reg == 2'd2);
            inv_c_reg[0]  <= rt_reg[row_reg];
            inv_c_reg[1]  <= up_reg[row_reg];
            inv_c_reg[2]  <= bk[row_reg];
            for (int i = 0; i < 3; i++)
            begin
                case (row_reg)
                    2'd0:    view_c_reg[i] <= rt_reg[i];
                    2'd1:    view_c_reg[i] <= up_reg[i];
                    default: view_c_reg[i] <= bk[i];
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = row_index_reg;
    assign view_c0   = view_c_reg[0];
    assign view_c1   = view_c_reg[1];
    assign view_c2   = view_c_reg[2];
    assign view_t    = view_t_reg;
    assign inv_c0    = inv_c_reg[0];
    assign inv_c1    = inv_c_reg[1];
    assign inv_c2    = inv_c_reg[2];
    assign inv_t     = inv_t_reg;
    assign last_row  = last_row_reg;

    a_last_is_row2: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_row_reg) |-> (row_index_reg == 2'd2))
        else $error("last row flagged on a row other than two");

    a_rows_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |=> !out_valid_reg)
        else $error("rows emitted on consecutive cycles");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == lav_pkg::B_SQ))
        else $error("popped job did not start the square sum");

    a_emit_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $past(state_reg == lav_pkg::B_ROW))
        else $error("row emitted outside the row phase");

endmodule
